### rtl/lbd_pkg.sv
// Shared types and constants for the LRU block buffer directory.
// Used by lbd_cell and lru_block_buffer_directory; depends on nothing.
package lbd_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  localparam int ACT_W   = 2;
  localparam int FILE_W  = 8;
  localparam int BLOCK_W = 24;
  localparam int TAG_W   = FILE_W + BLOCK_W;
  localparam int SLOT_W  = 4;
  localparam int STAT_W  = 2;
  localparam int IN_W    = 32;
  localparam int OUT_W   = 40;

  // action codes
  localparam logic [ACT_W-1:0] ACT_ACCESS = 2'd0;
  localparam logic [ACT_W-1:0] ACT_PIN    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_UNPIN  = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_ALL_PIN = 2'd1;
  localparam logic [STAT_W-1:0] ST_ABSENT  = 2'd2;

  // one directory entry as held by a recency cell
  typedef struct packed {
    logic [IDX_W-1:0] slot;
    logic [TAG_W-1:0] tag;
    logic             valid;
    logic             pinned;
  } entry_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic shift;
    logic pin_we;
    logic pin_val;
  } cell_ctrl_t;

  // slot index to the 4-bit result field (truncate or zero-extend)
  function automatic logic [SLOT_W-1:0] slot_field(input logic [IDX_W-1:0] s);
    logic [IDX_W+SLOT_W-1:0] wide;
    wide = {{SLOT_W{1'b0}}, s};
    return wide[SLOT_W-1:0];
  endfunction

endpackage

### rtl/lbd_cell.sv
// One recency position of the directory: holds an entry, matches its tag,
// and takes its upper neighbour's entry when the order shifts. Uses lbd_pkg.
module lbd_cell
  import lbd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] rst_slot,
  input  cell_ctrl_t       ctrl,
  input  entry_t           nxt,
  input  logic [TAG_W-1:0] req_tag,
  input  logic [IDX_W-1:0] fill_slot,
  output entry_t           ent,
  output logic             match,
  output logic             is_fill,
  output logic             cand
);

  logic [IDX_W-1:0] slot;
  logic [TAG_W-1:0] tag;
  logic             valid;
  logic             pinned;

  // control part of the entry
  always_ff @(posedge clk) begin
    if (rst) begin
      slot   <= rst_slot;
      valid  <= 1'b0;
      pinned <= 1'b0;
    end else if (ctrl.shift) begin
      slot   <= nxt.slot;
      valid  <= nxt.valid;
      pinned <= nxt.pinned;
    end else if (ctrl.pin_we) begin
      pinned <= ctrl.pin_val;
    end
  end

  // tag payload, no reset
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      tag <= nxt.tag;
    end
  end

  assign ent     = '{slot: slot, tag: tag, valid: valid, pinned: pinned};
  assign match   = valid && (tag == req_tag);
  assign is_fill = (slot == fill_slot);
  assign cand    = valid && !pinned;

endmodule

### rtl/lru_block_buffer_directory.sv
// Directory of a fully associative block buffer, LRU order skipping pinned blocks.
// Each request takes a lookup state, then an update state over the row of recency
// cells, where the result is registered; a stalled result holds the update state.
// A new request is accepted only as the previous one finishes its update state.
// Reset clears valid and pin marks, restores the recency order and the fill
// count at once; tags are undefined until written. Uses lbd_pkg and lbd_cell.
module lru_block_buffer_directory
  import lbd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // file_number[7:0], block_number[31:8]
  input  logic [ACT_W-1:0] s_tuser,   // action[1:0]
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // hit[0], slot[4:1], evicted[5],
                                      // evicted_file[13:6], evicted_block[37:14],
                                      // status[39:38]
);

  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_UPD} state_t;

  state_t state;

  // registered request
  logic [ACT_W-1:0] act_r;
  logic [TAG_W-1:0] tag_r;

  // lookup results
  logic [ENTRIES-1:0] sel_r;
  logic [ENTRIES-1:0] mask_r;
  logic               hit_r;
  logic               full_r;
  logic               found_r;
  entry_t             sel_ent_r;

  logic [CNT_W-1:0] used;

  // cell row
  entry_t             ent   [ENTRIES];
  entry_t             nxt   [ENTRIES];
  cell_ctrl_t         ctrl  [ENTRIES];
  logic [ENTRIES-1:0] match_v;
  logic [ENTRIES-1:0] fill_v;
  logic [ENTRIES-1:0] cand_v;
  entry_t             tail;

  logic               accept;
  logic               can_finish;
  logic               do_move;
  logic               do_pin;
  logic               full;
  logic [ENTRIES-1:0] victim;
  logic [ENTRIES-1:0] sel;
  entry_t             sel_ent;

  logic               o_hit;
  logic [SLOT_W-1:0]  o_slot;
  logic               o_ev;
  logic [TAG_W-1:0]   o_ev_tag;
  logic [STAT_W-1:0]  o_status;

  assign can_finish = !m_tvalid || m_tready;
  assign s_tready   = (state == S_IDLE) || ((state == S_UPD) && can_finish);
  assign accept     = s_tvalid && s_tready;

  assign do_move = (state == S_UPD) && can_finish && (act_r == ACT_ACCESS) && found_r;
  assign do_pin  = (state == S_UPD) && can_finish && found_r &&
                   ((act_r == ACT_PIN) || (act_r == ACT_UNPIN));

  // entry moved to the most recent end
  assign tail = '{slot:   sel_ent_r.slot,
                  tag:    hit_r ? sel_ent_r.tag : tag_r,
                  valid:  1'b1,
                  pinned: hit_r ? sel_ent_r.pinned : 1'b0};

  // row of recency cells, position 0 least recent
  for (genvar q = 0; q < ENTRIES; q++) begin : g_cell
    if (q == ENTRIES - 1) begin : g_tail
      assign nxt[q]        = tail;
      assign ctrl[q].shift = do_move;
    end else begin : g_mid
      assign nxt[q]        = ent[q+1];
      assign ctrl[q].shift = do_move && mask_r[q];
    end
    assign ctrl[q].pin_we  = do_pin && sel_r[q];
    assign ctrl[q].pin_val = (act_r == ACT_PIN);

    lbd_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .rst_slot  (IDX_W'(q)),
      .ctrl      (ctrl[q]),
      .nxt       (nxt[q]),
      .req_tag   (tag_r),
      .fill_slot (used[IDX_W-1:0]),
      .ent       (ent[q]),
      .match     (match_v[q]),
      .is_fill   (fill_v[q]),
      .cand      (cand_v[q])
    );
  end

  // lookup: choose the position to act on
  assign full   = (used == CNT_W'(ENTRIES));
  assign victim = cand_v & (~cand_v + ENTRIES'(1));

  always_comb begin
    unique case (act_r)
      ACT_ACCESS: begin
        if (|match_v) begin
          sel = match_v;
        end else if (!full) begin
          sel = fill_v;
        end else begin
          sel = victim;
        end
      end
      ACT_PIN, ACT_UNPIN: sel = match_v;
      default:            sel = '0;
    endcase
  end

  // selected entry, and-or over the row
  always_comb begin
    sel_ent = '0;
    for (int p = 0; p < ENTRIES; p++) begin
      if (sel[p]) begin
        sel_ent.slot   = sel_ent.slot   | ent[p].slot;
        sel_ent.tag    = sel_ent.tag    | ent[p].tag;
        sel_ent.valid  = sel_ent.valid  | ent[p].valid;
        sel_ent.pinned = sel_ent.pinned | ent[p].pinned;
      end
    end
  end

  // result fields
  always_comb begin
    o_hit    = 1'b0;
    o_slot   = '0;
    o_ev     = 1'b0;
    o_ev_tag = '0;
    o_status = ST_OK;
    unique case (act_r)
      ACT_ACCESS: begin
        if (found_r) begin
          o_hit  = hit_r;
          o_slot = slot_field(sel_ent_r.slot);
          if (!hit_r && full_r) begin
            o_ev     = 1'b1;
            o_ev_tag = sel_ent_r.tag;
          end
        end else begin
          o_status = ST_ALL_PIN;
        end
      end
      ACT_PIN, ACT_UNPIN: begin
        if (found_r) begin
          o_hit  = 1'b1;
          o_slot = slot_field(sel_ent_r.slot);
        end else begin
          o_status = ST_ABSENT;
        end
      end
      default: ;
    endcase
  end

  // sequencer, fill count and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      used     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (accept) state <= S_LOOK;
        S_LOOK: state <= S_UPD;
        S_UPD: begin
          if (can_finish) begin
            m_tvalid <= 1'b1;
            if (do_move && !hit_r && !full_r) begin
              used <= used + CNT_W'(1);
            end
            state <= accept ? S_LOOK : S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (m_tvalid && m_tready && !((state == S_UPD) && can_finish)) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r <= s_tuser;
      tag_r <= {s_tdata[FILE_W-1:0], s_tdata[IN_W-1:FILE_W]};
    end
    if (state == S_LOOK) begin
      sel_r     <= sel;
      mask_r    <= ~(sel - ENTRIES'(1));
      hit_r     <= |match_v;
      full_r    <= full;
      found_r   <= |sel;
      sel_ent_r <= sel_ent;
    end
    if ((state == S_UPD) && can_finish) begin
      m_tdata <= {o_status, o_ev_tag[BLOCK_W-1:0], o_ev_tag[TAG_W-1:BLOCK_W],
                  o_ev, o_slot, o_hit};
    end
  end

endmodule

### verif/lru_block_buffer_directory_tb.sv
// Self-checking testbench for the LRU block buffer directory: directed table, then random
// access, pin, unpin and unused-code requests against an in-bench model of the recency directory.
// Depends on lbd_pkg and lru_block_buffer_directory.
module lru_block_buffer_directory_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lbd_pkg::*;

  localparam int LIMIT = 400000;
  localparam int POOL_N = 24;
  localparam int RANDOM_ITEMS = 1150;
  localparam int RX_HOLD_AT = 400;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int TX_PAUSE_AT = 700;
  localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

  typedef struct packed {
    logic                hit;
    logic [SLOT_W-1:0]   slot;
    logic                evicted;
    logic [FILE_W-1:0]   ev_file;
    logic [BLOCK_W-1:0]  ev_block;
    logic [STAT_W-1:0]   status;
  } reply_t;

  typedef struct {
    logic [ACT_W-1:0] act;
    logic [TAG_W-1:0] tag;
    int               reps;
    bit               typed;
    reply_t           want;
  } plan_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic [ACT_W-1:0] s_tuser = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  // directory model state
  logic [TAG_W-1:0] dir_tag [ENTRIES];
  bit               dir_valid [ENTRIES];
  bit               dir_pinned [ENTRIES];
  int               lru_order [ENTRIES];
  int               fill_count;

  reply_t           pending_replies [$];
  plan_row_t        directed_plan [$];
  logic [TAG_W-1:0] tag_pool [POOL_N];
  int               mismatch_count = 0;
  int               reply_count = 0;
  int               sent_count = 0;
  int               cycle_count = 0;
  bit               tx_calm = 1'b0;
  bit               rx_calm = 1'b0;
  bit               tx_paused = 1'b0;

  lru_block_buffer_directory i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // move a slot to the most recent end of the recency order
  function automatic void promote_slot(input int slot);
    int p;
    p = 0;
    while (p < ENTRIES && lru_order[p] != slot) p++;
    if (p < ENTRIES) begin
      for (int q = p; q + 1 < ENTRIES; q++) lru_order[q] = lru_order[q + 1];
      lru_order[ENTRIES - 1] = slot;
    end
  endfunction

  // apply one request to the directory model and return its reply
  function automatic reply_t directory_lookup(input logic [ACT_W-1:0] act,
                                              input logic [TAG_W-1:0] tag);
    reply_t r;
    int     hit_at;
    int     target;
    int     c;
    r = '0;
    hit_at = -1;
    target = -1;
    for (int k = 0; k < ENTRIES; k++)
      if (hit_at < 0 && dir_valid[k] && dir_tag[k] == tag) hit_at = k;
    case (act)
      ACT_ACCESS: begin
        if (hit_at >= 0) begin
          r.hit = 1'b1;
          r.slot = SLOT_W'(hit_at);
          promote_slot(hit_at);
        end else begin
          if (fill_count < ENTRIES) begin
            for (int k = 0; k < ENTRIES; k++)
              if (target < 0 && !dir_valid[k]) target = k;
          end else begin
            // oldest entry that is not pinned
            for (int p = 0; p < ENTRIES; p++) begin
              c = lru_order[p];
              if (target < 0 && dir_valid[c] && !dir_pinned[c]) target = c;
            end
            if (target >= 0) begin
              r.evicted = 1'b1;
              r.ev_file = dir_tag[target][TAG_W-1:BLOCK_W];
              r.ev_block = dir_tag[target][BLOCK_W-1:0];
              fill_count--;
            end
          end
          if (target >= 0) begin
            dir_tag[target] = tag;
            dir_valid[target] = 1'b1;
            dir_pinned[target] = 1'b0;
            fill_count++;
            promote_slot(target);
            r.slot = SLOT_W'(target);
          end else begin
            r.status = ST_ALL_PIN;
          end
        end
      end
      ACT_PIN, ACT_UNPIN: begin
        if (hit_at >= 0) begin
          dir_pinned[hit_at] = (act == ACT_PIN);
          r.hit = 1'b1;
          r.slot = SLOT_W'(hit_at);
        end else begin
          r.status = ST_ABSENT;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // offer one request after a random gap; the reply is predicted on acceptance
  task automatic offer(input logic [ACT_W-1:0] act, input logic [TAG_W-1:0] tag,
                       input bit typed, input reply_t want);
    int     gap;
    reply_t r;
    gap = tx_calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= {tag[BLOCK_W-1:0], tag[TAG_W-1:BLOCK_W]};
    // ready is settled mid-cycle; the following rising edge takes the request
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    r = directory_lookup(act, tag);
    pending_replies.push_back(typed ? want : r);
    sent_count++;
  endtask

  task automatic plan_row(input logic [ACT_W-1:0] act, input logic [TAG_W-1:0] tag,
                          input int reps, input bit typed, input bit hit,
                          input int slot, input logic [STAT_W-1:0] status);
    plan_row_t row;
    row.act = act;
    row.tag = tag;
    row.reps = reps;
    row.typed = typed;
    row.want = '0;
    row.want.hit = hit;
    row.want.slot = SLOT_W'(slot);
    row.want.status = status;
    directed_plan.push_back(row);
  endtask

  // pin most or all buffered blocks, try to insert, then release some of them
  task automatic pin_sweep();
    bit pin_all;
    pin_all = 1'($urandom_range(0, 1));
    for (int s = 0; s < ENTRIES; s++)
      if (dir_valid[s] && (pin_all || $urandom_range(0, 3) != 0))
        offer(ACT_PIN, dir_tag[s], 1'b0, '0);
    repeat (2) offer(ACT_ACCESS, TAG_W'($urandom), 1'b0, '0);
    for (int s = 0; s < ENTRIES; s++)
      if (dir_valid[s] && $urandom_range(0, 1) == 1)
        offer(ACT_UNPIN, dir_tag[s], 1'b0, '0);
  endtask

  // mixed requests over a small pool of tags so hits and evictions are common
  task automatic mixed_run(input int count);
    int               r;
    logic [TAG_W-1:0] tag;
    logic [ACT_W-1:0] act;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 19) == 0) tag_pool[$urandom_range(0, POOL_N - 1)] = $urandom;
      tag = ($urandom_range(0, 9) == 0) ? TAG_W'($urandom)
                                        : tag_pool[$urandom_range(0, POOL_N - 1)];
      if (r < 3) act = ACT_SPARE;
      else if (r < 65) act = ACT_ACCESS;
      else if (r < 82) act = ACT_PIN;
      else act = ACT_UNPIN;
      offer(act, tag, 1'b0, '0);
      // one pause until the block has drained completely
      if (!tx_paused && sent_count >= TX_PAUSE_AT) begin
        tx_paused = 1'b1;
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge clk);
      end
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
      mismatch_count++;
    end
  endtask

  // receiver: random stalls, one long hold, compare each reply in order
  initial begin
    bit held;
    held = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      int     stall;
      reply_t got;
      reply_t want;
      if (!held && reply_count >= RX_HOLD_AT) begin
        held = 1'b1;
        stall = RX_HOLD_CYCLES;
      end else begin
        stall = rx_calm ? 0 : $urandom_range(0, 14);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      // sample mid-cycle; the following rising edge takes the reply
      do @(negedge clk); while (!m_tvalid);
      got.hit = m_tdata[0];
      got.slot = m_tdata[4:1];
      got.evicted = m_tdata[5];
      got.ev_file = m_tdata[13:6];
      got.ev_block = m_tdata[37:14];
      got.status = m_tdata[39:38];
      @(posedge clk);
      if (pending_replies.size() == 0) begin
        $display("%0t: reply with none expected, expected none, actual %0h",
                 $realtime, got);
        mismatch_count++;
      end else begin
        want = pending_replies.pop_front();
        check_field("hit", want.hit, got.hit);
        check_field("slot", want.slot, got.slot);
        check_field("evicted", want.evicted, got.evicted);
        check_field("evicted_file", want.ev_file, got.ev_file);
        check_field("evicted_block", want.ev_block, got.ev_block);
        check_field("status", want.status, got.status);
      end
      reply_count++;
      if (reply_count % 50 == 0) rx_calm = ($urandom_range(0, 3) == 0);
    end
  end

  // stimulus
  initial begin
    plan_row_t row;
    for (int s = 0; s < ENTRIES; s++) begin
      dir_valid[s] = 1'b0;
      dir_pinned[s] = 1'b0;
      lru_order[s] = s;
    end
    fill_count = 0;
    for (int i = 0; i < POOL_N; i++) tag_pool[i] = $urandom;

    // directed table: typed rows are read straight off the behaviour
    plan_row(ACT_ACCESS, 32'h0000_0000, 1, 1'b1, 1'b0, 0, ST_OK);
    plan_row(ACT_ACCESS, 32'hFFFF_FFFF, 1, 1'b1, 1'b0, 1, ST_OK);
    plan_row(ACT_ACCESS, 32'h0000_0000, 1, 1'b1, 1'b1, 0, ST_OK);
    plan_row(ACT_PIN,    32'h0700_0123, 1, 1'b1, 1'b0, 0, ST_ABSENT);
    plan_row(ACT_UNPIN,  32'h0700_0123, 1, 1'b1, 1'b0, 0, ST_ABSENT);
    plan_row(ACT_SPARE,  32'hFFFF_FFFF, 1, 1'b1, 1'b0, 0, ST_OK);
    plan_row(ACT_PIN,    32'hFFFF_FFFF, 1, 1'b1, 1'b1, 1, ST_OK);
    // fill the remaining slots, then force an eviction past the pinned block
    plan_row(ACT_ACCESS, 32'h0100_0000, ENTRIES - 2, 1'b0, 1'b0, 0, ST_OK);
    plan_row(ACT_ACCESS, 32'h0200_0000, 1, 1'b0, 1'b0, 0, ST_OK);
    plan_row(ACT_UNPIN,  32'hFFFF_FFFF, 1, 1'b1, 1'b1, 1, ST_OK);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_calm = 1'b1;
    foreach (directed_plan[i]) begin
      row = directed_plan[i];
      for (int k = 0; k < row.reps; k++) offer(row.act, row.tag + k, row.typed, row.want);
    end

    // random part: mostly mixed runs, with regular pin sweeps to reach the all-pinned case
    pin_sweep();
    while (sent_count < RANDOM_ITEMS + 25) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0) pin_sweep();
      else mixed_run(30);
    end
    s_tvalid <= 1'b0;

    while (pending_replies.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/lbd_pkg.sv
rtl/lbd_cell.sv
rtl/lru_block_buffer_directory.sv
verif/lru_block_buffer_directory_tb.sv
